/* hw/rtl/sfmf_pkg.sv */
// sfmf_pkg: widths, reset values, codes and shared types of the sonar frame median filter
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package sfmf_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned DELTA_W  = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned STEP_W   = 8;

  // median window length
  localparam int unsigned WINDOW_LENGTH_DEF = 3;

  // configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_RANGE_LIMIT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TICK_STEP     = 2'd2;

  // register reset values
  localparam logic [HEIGHT_W-1:0] RANGE_LIMIT_RST   = 13'd5000;
  localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RST = 10'd200;
  localparam logic [STEP_W-1:0]   TICK_STEP_RST     = 8'd50;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // configuration seen by the datapath
  typedef struct packed {
    logic [HEIGHT_W-1:0] range_limit;
    logic [LIMIT_W-1:0]  timeout_limit;
    logic [STEP_W-1:0]   tick_step;
  } cfg_t;

endpackage

/* hw/rtl/sfmf_in_if.sv */
// sfmf_in_if: input channel, one tick or one received byte per transfer
// depends on sfmf_pkg
`timescale 1ns / 1ps

interface sfmf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sfmf_pkg::BYTE_W-1:0]  byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

/* hw/rtl/sfmf_out_if.sv */
// sfmf_out_if: result channel, one result per transfer
// depends on sfmf_pkg
`timescale 1ns / 1ps

interface sfmf_out_if;
  logic                                valid;
  logic                                ready;
  logic                                send_trigger;
  logic [sfmf_pkg::RAW_W-1:0]          raw_height_mm;
  logic [sfmf_pkg::HEIGHT_W-1:0]       filtered_height_mm;
  logic signed [sfmf_pkg::DELTA_W-1:0] height_delta_mm;
  logic [sfmf_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output send_trigger, output raw_height_mm,
                  output filtered_height_mm, output height_delta_mm, output status,
                  input ready);
  modport sink   (input valid, input send_trigger, input raw_height_mm,
                  input filtered_height_mm, input height_delta_mm, input status,
                  output ready);
endinterface

/* hw/rtl/sfmf_cfg.sv */
// sfmf_cfg: apb register file holding range limit, timeout limit and tick step
// depends on sfmf_pkg
`timescale 1ns / 1ps

module sfmf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfmf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sfmf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sfmf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output sfmf_pkg::cfg_t                      cfg_o
);

  logic [sfmf_pkg::HEIGHT_W-1:0]  range_limit_q;
  logic [sfmf_pkg::LIMIT_W-1:0]   timeout_limit_q;
  logic [sfmf_pkg::STEP_W-1:0]    tick_step_q;
  logic [sfmf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sfmf_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_limit_q   <= sfmf_pkg::RANGE_LIMIT_RST;
      timeout_limit_q <= sfmf_pkg::TIMEOUT_LIMIT_RST;
      tick_step_q     <= sfmf_pkg::TICK_STEP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfmf_pkg::REG_RANGE_LIMIT:   range_limit_q   <= pwdata[sfmf_pkg::HEIGHT_W-1:0];
        sfmf_pkg::REG_TIMEOUT_LIMIT: timeout_limit_q <= pwdata[sfmf_pkg::LIMIT_W-1:0];
        sfmf_pkg::REG_TICK_STEP:     tick_step_q     <= pwdata[sfmf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sfmf_pkg::REG_RANGE_LIMIT:
        prdata = sfmf_pkg::APB_DATA_W'(range_limit_q);
      sfmf_pkg::REG_TIMEOUT_LIMIT:
        prdata = sfmf_pkg::APB_DATA_W'(timeout_limit_q);
      sfmf_pkg::REG_TICK_STEP:
        prdata = sfmf_pkg::APB_DATA_W'(tick_step_q);
      default: prdata = '0;
    endcase
  end

  assign cfg_o.range_limit   = range_limit_q;
  assign cfg_o.timeout_limit = timeout_limit_q;
  assign cfg_o.tick_step     = tick_step_q;

endmodule

/* hw/rtl/sfmf_median.sv */
// sfmf_median: rank-based median select over the height window
// depends on sfmf_pkg
`timescale 1ns / 1ps

module sfmf_median #(
  parameter int unsigned WINDOW_LENGTH = sfmf_pkg::WINDOW_LENGTH_DEF
) (
  input  logic [sfmf_pkg::HEIGHT_W-1:0] win_i [WINDOW_LENGTH],
  output logic [sfmf_pkg::HEIGHT_W-1:0] median_o
);

  localparam int unsigned RANK_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned MID    = WINDOW_LENGTH / 2;

  logic [RANK_W-1:0] rank [WINDOW_LENGTH];

  // stable rank of each entry: ties broken by position, so ranks form a permutation
  always_comb begin
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LENGTH; j++) begin
        if (j != i) begin
          if ((win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // exactly one entry holds the middle rank
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        median_o = median_o | win_i[i];
      end
    end
  end

endmodule

/* hw/rtl/sfmf_core.sv */
// sfmf_core: input register, frame assembly, timeout, median window and result register
// depends on sfmf_pkg, sfmf_in_if, sfmf_out_if and sfmf_median
`timescale 1ns / 1ps

module sfmf_core #(
  parameter int unsigned WINDOW_LENGTH = sfmf_pkg::WINDOW_LENGTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfmf_pkg::cfg_t  cfg_i,
  sfmf_in_if.sink         in_ch,
  sfmf_out_if.source      out_ch
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned HW     = sfmf_pkg::HEIGHT_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // input register
  logic                          in_valid_q;
  logic                          in_kind_q;
  logic [sfmf_pkg::BYTE_W-1:0]   in_byte_q;

  // block state
  phase_e                        phase_q, phase_d;
  logic [sfmf_pkg::BYTE_W-1:0]   high_byte_q, high_byte_d;
  logic [sfmf_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [sfmf_pkg::STATUS_W-1:0] status_q, status_d;
  logic [sfmf_pkg::RAW_W-1:0]    raw_q, raw_d;
  logic [HW-1:0]                 win_q [WINDOW_LENGTH];
  logic [HW-1:0]                 win_d [WINDOW_LENGTH];
  logic [SLOT_W-1:0]             slot_q, slot_d;
  logic [HW-1:0]                 filt_q, filt_d;
  logic [HW-1:0]                 prev_q, prev_d;

  // result register
  logic                          out_valid_q;
  logic                          res_trig_q, res_trig_d;
  logic [sfmf_pkg::RAW_W-1:0]    res_raw_q;
  logic [HW-1:0]                 res_filt_q;
  logic [sfmf_pkg::DELTA_W-1:0]  res_delta_q, res_delta_d;
  logic [sfmf_pkg::STATUS_W-1:0] res_status_q;

  // datapath helpers
  logic                          advance;
  logic [sfmf_pkg::RAW_W-1:0]    raw_asm;
  logic [SLOT_W-1:0]             slot_idx;
  logic [SLOT_W-1:0]             slot_next;
  logic [HW-1:0]                 win_ins [WINDOW_LENGTH];
  logic [HW-1:0]                 median;

  // handshake: the result register frees as it is taken
  assign advance      = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || advance;

  // candidate window with the newly assembled height written in
  assign raw_asm   = {high_byte_q, in_byte_q};
  assign slot_idx  = (32'(slot_q) >= WINDOW_LENGTH) ? '0 : slot_q;
  assign slot_next = (slot_idx == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_idx + SLOT_W'(1);

  always_comb begin
    win_ins           = win_q;
    win_ins[slot_idx] = raw_asm[HW-1:0];
  end

  sfmf_median #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_median (
    .win_i    (win_ins),
    .median_o (median)
  );

  // next state and result for the item in the input register
  always_comb begin
    phase_d     = phase_q;
    high_byte_d = high_byte_q;
    count_d     = count_q;
    status_d    = status_q;
    raw_d       = raw_q;
    win_d       = win_q;
    slot_d      = slot_q;
    filt_d      = filt_q;
    prev_d      = prev_q;
    res_trig_d  = 1'b0;
    res_delta_d = '0;
    if (in_kind_q == sfmf_pkg::KIND_TICK) begin
      res_trig_d = 1'b1;
      phase_d    = PH_HIGH;
      if (count_q < sfmf_pkg::COUNT_W'(cfg_i.timeout_limit)) begin
        count_d = count_q + sfmf_pkg::COUNT_W'(cfg_i.tick_step);
      end else begin
        status_d = sfmf_pkg::STATUS_NONE;
      end
    end else begin
      unique case (phase_q)
        PH_HIGH: begin
          high_byte_d = in_byte_q;
          phase_d     = PH_LOW;
        end
        PH_LOW: begin
          raw_d = raw_asm;
          if (raw_asm < sfmf_pkg::RAW_W'(cfg_i.range_limit)) begin
            win_d    = win_ins;
            slot_d   = slot_next;
            filt_d   = median;
            status_d = sfmf_pkg::STATUS_VALID;
          end else begin
            status_d = sfmf_pkg::STATUS_RANGE;
          end
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      count_d     = '0;
      res_delta_d = sfmf_pkg::DELTA_W'(filt_d) - sfmf_pkg::DELTA_W'(prev_q);
      prev_d      = filt_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_kind_q <= in_ch.kind;
      in_byte_q <= in_ch.byte_value;
    end
  end

  // block state, updated as an item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      high_byte_q <= '0;
      count_q     <= '0;
      status_q    <= sfmf_pkg::STATUS_NONE;
      raw_q       <= '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= '0;
      end
      slot_q      <= '0;
      filt_q      <= '0;
      prev_q      <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      high_byte_q <= high_byte_d;
      count_q     <= count_d;
      status_q    <= status_d;
      raw_q       <= raw_d;
      win_q       <= win_d;
      slot_q      <= slot_d;
      filt_q      <= filt_d;
      prev_q      <= prev_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_trig_q   <= res_trig_d;
      res_raw_q    <= raw_d;
      res_filt_q   <= filt_d;
      res_delta_q  <= res_delta_d;
      res_status_q <= status_d;
    end
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.send_trigger       = res_trig_q;
  assign out_ch.raw_height_mm      = res_raw_q;
  assign out_ch.filtered_height_mm = res_filt_q;
  assign out_ch.height_delta_mm    = res_delta_q;
  assign out_ch.status             = res_status_q;

endmodule

/* hw/rtl/sonar_frame_median_filter.sv */
// sonar_frame_median_filter: an accepted item passes the input register, then the result
// register; one item per cycle while the output channel takes results, set by the single pass
// from the input register through the median select to the result register
// reset clears the valid flags of both channel registers, the frame state, the timeout counter
// and the median window to zeros, and loads the registers with 5000 mm, 200 ms and 50 ms
// depends on sfmf_pkg, sfmf_in_if, sfmf_out_if, sfmf_cfg and sfmf_core
`timescale 1ns / 1ps

module sonar_frame_median_filter #(
  parameter int unsigned WINDOW_LENGTH = sfmf_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfmf_in_if.sink                         in_i,
  sfmf_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfmf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sfmf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sfmf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  sfmf_pkg::cfg_t cfg;

  // configuration registers
  sfmf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // frame assembly and filtering datapath
  sfmf_core #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_i),
    .out_ch (out_o)
  );

endmodule

/* tb/sfmf_checker.sv */
// sfmf_checker: watches the register port and both channels of the sonar frame median filter,
// predicts each result from the accepted items and compares it field by field
// depends on sfmf_pkg, sfmf_in_if and sfmf_out_if
`timescale 1ns / 1ps

module sfmf_checker
  import sfmf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfmf_in_if                    in_ch_i,
  sfmf_out_if                   out_ch_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic                  pready_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef enum logic [1:0] {
    FRAME_IDLE,
    FRAME_WANT_HIGH,
    FRAME_WANT_LOW
  } frame_phase_e;

  typedef struct packed {
    logic                send_trigger;
    logic [RAW_W-1:0]    raw_height;
    logic [HEIGHT_W-1:0] filtered_height;
    logic [DELTA_W-1:0]  height_delta;
    logic [STATUS_W-1:0] status;
  } height_report_t;

  // shadow of the registers and of the frame state
  cfg_t                cfg;
  frame_phase_e        phase;
  logic [BYTE_W-1:0]   held_high;
  logic [COUNT_W-1:0]  timeout_ms;
  logic [STATUS_W-1:0] status_now;
  logic [RAW_W-1:0]    last_raw;
  logic [HEIGHT_W-1:0] window [WINDOW_LENGTH_DEF];
  int unsigned         next_slot;
  logic [HEIGHT_W-1:0] filtered_now;
  logic [HEIGHT_W-1:0] filtered_prev;

  height_report_t      height_reports_q[$];
  int                  mismatches;
  int                  checked;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s differs, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // middle value of three: clamp the third between the smaller and larger of the others
  function automatic logic [HEIGHT_W-1:0] middle_of_three(input logic [HEIGHT_W-1:0] a,
                                                          input logic [HEIGHT_W-1:0] b,
                                                          input logic [HEIGHT_W-1:0] c);
    logic [HEIGHT_W-1:0] lo;
    logic [HEIGHT_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // advance the frame assembler and median window by one item
  task automatic filter_height_item(input logic kind, input logic [BYTE_W-1:0] value,
                                    output height_report_t r);
    logic [RAW_W-1:0] frame;
    frame = {held_high, value};
    r = '0;
    if (kind == KIND_TICK) begin
      r.send_trigger = 1'b1;
      phase = FRAME_WANT_HIGH;
      if (timeout_ms < cfg.timeout_limit) begin
        timeout_ms = timeout_ms + cfg.tick_step;
      end else begin
        status_now = STATUS_NONE;
      end
    end else begin
      case (phase)
        FRAME_WANT_HIGH: begin
          held_high = value;
          phase = FRAME_WANT_LOW;
        end
        FRAME_WANT_LOW: begin
          last_raw = frame;
          if (frame < cfg.range_limit) begin
            window[next_slot] = frame[HEIGHT_W-1:0];
            next_slot = (next_slot == WINDOW_LENGTH_DEF - 1) ? 0 : next_slot + 1;
            filtered_now = middle_of_three(window[0], window[1], window[2]);
            status_now = STATUS_VALID;
          end else begin
            status_now = STATUS_RANGE;
          end
          phase = FRAME_IDLE;
        end
        default: begin
          phase = FRAME_IDLE;
        end
      endcase
      timeout_ms = '0;
      r.height_delta = {1'b0, filtered_now} - {1'b0, filtered_prev};
      filtered_prev = filtered_now;
    end
    r.raw_height      = last_raw;
    r.filtered_height = filtered_now;
    r.status          = status_now;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    height_report_t want;
    height_report_t got;
    if (!rst_ni) begin
      cfg.range_limit   = RANGE_LIMIT_RST;
      cfg.timeout_limit = TIMEOUT_LIMIT_RST;
      cfg.tick_step     = TICK_STEP_RST;
      phase         = FRAME_IDLE;
      held_high     = '0;
      timeout_ms    = '0;
      status_now    = STATUS_NONE;
      last_raw      = '0;
      next_slot     = 0;
      filtered_now  = '0;
      filtered_prev = '0;
      for (int i = 0; i < WINDOW_LENGTH_DEF; i++) window[i] = '0;
      height_reports_q.delete();
      pending_o <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_ch_i.valid && out_ch_i.ready) begin
        got.send_trigger    = out_ch_i.send_trigger;
        got.raw_height      = out_ch_i.raw_height_mm;
        got.filtered_height = out_ch_i.filtered_height_mm;
        got.height_delta    = out_ch_i.height_delta_mm;
        got.status          = out_ch_i.status;
        if (height_reports_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.raw_height, 0);
        end else begin
          want = height_reports_q.pop_front();
          checked++;
          if (got.send_trigger !== want.send_trigger)
            report_mismatch("send_trigger", got.send_trigger, want.send_trigger);
          if (got.raw_height !== want.raw_height)
            report_mismatch("raw_height_mm", got.raw_height, want.raw_height);
          if (got.filtered_height !== want.filtered_height)
            report_mismatch("filtered_height_mm", got.filtered_height, want.filtered_height);
          if (got.height_delta !== want.height_delta)
            report_mismatch("height_delta_mm", $signed(got.height_delta),
                            $signed(want.height_delta));
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
      end

      // register write on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[REG_IDX_W+1:2])
          REG_RANGE_LIMIT:   cfg.range_limit   = pwdata_i[HEIGHT_W-1:0];
          REG_TIMEOUT_LIMIT: cfg.timeout_limit = pwdata_i[LIMIT_W-1:0];
          REG_TICK_STEP:     cfg.tick_step     = pwdata_i[STEP_W-1:0];
          default: ;
        endcase
      end

      // input transfer: predict its result
      if (in_ch_i.valid && in_ch_i.ready) begin
        filter_height_item(in_ch_i.kind, in_ch_i.byte_value, want);
        height_reports_q.push_back(want);
      end
      pending_o <= height_reports_q.size();
    end
    fail_count_o <= mismatches;
    checked_o    <= checked;
  end

endmodule

/* tb/tb_sonar_frame_median_filter.sv */
// tb_sonar_frame_median_filter: clock, reset, stimulus and verdict for the sonar frame filter
// depends on sfmf_pkg, sfmf_in_if, sfmf_out_if, sfmf_checker and the filter rtl
`timescale 1ns / 1ps

module tb_sonar_frame_median_filter;
  import sfmf_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    fail_count;
  int                    pending;
  int                    checked;
  int                    items_sent;
  int                    settings_used;
  bit                    quiet_gaps;
  logic [HEIGHT_W-1:0]   range_now;

  sfmf_in_if  in_ch ();
  sfmf_out_if out_ch ();

  sonar_frame_median_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sfmf_checker height_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    #5_000_000;
    $display("timed out with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall before each transfer, ready held high when no stall is drawn
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = quiet_gaps ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk_i);
    end
  end

  // one item on the input channel, after a random gap
  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
    int unsigned gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.byte_value <= value;
    @(posedge clk_i);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk_i);
    items_sent++;
  endtask

  // tick, then the height as high and low byte
  task automatic send_frame(input logic [RAW_W-1:0] height);
    send_item(KIND_TICK, BYTE_W'($urandom));
    send_item(KIND_BYTE, height[RAW_W-1:BYTE_W]);
    send_item(KIND_BYTE, height[BYTE_W-1:0]);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup then access cycle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [HEIGHT_W-1:0] range_mm,
                                input logic [LIMIT_W-1:0] timeout_ms,
                                input logic [STEP_W-1:0] step_ms);
    drain_results();
    write_reg(REG_RANGE_LIMIT, APB_DATA_W'(range_mm));
    write_reg(REG_TIMEOUT_LIMIT, APB_DATA_W'(timeout_ms));
    write_reg(REG_TICK_STEP, APB_DATA_W'(step_ms));
    range_now = range_mm;
    settings_used++;
  endtask

  // mostly in-range heights, some right at the limit, the rest anything
  function automatic logic [RAW_W-1:0] pick_height();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60 && range_now != 0)
      return RAW_W'($urandom_range(0, range_now - 1));
    else if (pick < 80)
      return RAW_W'(range_now) + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
    else
      return RAW_W'($urandom);
  endfunction

  task automatic run_random_phase(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_height());
      end else if (pick < 80) begin
        // run of ticks without bytes, drives the timeout
        repeat ($urandom_range(1, 8)) send_item(KIND_TICK, BYTE_W'($urandom));
      end else if (pick < 90) begin
        send_item($urandom_range(0, 1) ? KIND_BYTE : KIND_TICK, BYTE_W'($urandom));
      end else begin
        // frame cut short after its high byte
        send_item(KIND_TICK, BYTE_W'($urandom));
        send_item(KIND_BYTE, BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_TICK;
    in_ch.byte_value <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_ni           <= 1'b0;
    range_now     = RANGE_LIMIT_RST;
    quiet_gaps    = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings
    send_item(KIND_BYTE, 8'hA5);
    send_frame(RAW_W'(RANGE_LIMIT_RST) - RAW_W'(1));
    send_frame(RAW_W'(RANGE_LIMIT_RST));
    send_frame(16'hFFFF);
    // re-armed frame: tick arrives after the high byte
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_frame(16'h0001);
    send_frame(16'h0000);
    repeat (5) send_item(KIND_TICK, 8'hFF);

    // directed: zero limits, every height out of range and every tick timed out
    apply_settings('0, '0, 8'hFF);
    send_frame(16'h0000);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'hFF);

    // random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(13'h1FFF, 10'd1000, 8'hFF);
        1: apply_settings(13'd1, 10'd1, 8'd1);
        2: apply_settings(RANGE_LIMIT_RST, TIMEOUT_LIMIT_RST, TICK_STEP_RST);
        3: apply_settings(13'h1FFF, 10'h3FF, 8'd0);
        default: apply_settings(HEIGHT_W'($urandom), LIMIT_W'($urandom), STEP_W'($urandom));
      endcase
      quiet_gaps = (p == 2 || p == 5);
      run_random_phase(145);
    end

    quiet_gaps = 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items under %0d register settings: frames, cut frames, stray bytes,",
             items_sent, settings_used);
    $display("tick runs into timeout, range edges; %0d results compared", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
